// ===== rtl/cnv2d_pkg.sv =====
// Shared types, constants and helper functions of the 3x3 zero-padded convolution block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cnv2d_pkg;

  // Geometry and sample size.
  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);

  // Register field widths.
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int COEF_W       = 16;
  localparam int COEF_ROW_W   = 3 * COEF_W;

  // Pixel and result counters run past W*H while the last rows drain.
  localparam int CNT_W = 27;

  // Arithmetic widths: unsigned sample times signed Q8.8, then two adder levels.
  localparam int PROD_W = SAMPLE_BITS + 1 + COEF_W;
  localparam int ROW_W  = PROD_W + 2;
  localparam int OUT_W  = 36;

  // Port widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;

  // Result queue; its depth bounds the results in flight.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = FIFO_PTR_W + 1;

  // Reset values of the registers.
  localparam logic [COEF_ROW_W-1:0]   COEF_TOP_RST = 48'hFF00_FF00_FF00;
  localparam logic [COEF_ROW_W-1:0]   COEF_MID_RST = 48'hFF00_0800_FF00;
  localparam logic [COEF_ROW_W-1:0]   COEF_BOT_RST = 48'hFF00_FF00_FF00;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST    = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST   = 16'd480;
  localparam logic [CNT_W-1:0]        NPIX_RST     = CNT_W'(640 * 480);

  // Register indexes on the configuration port (byte address 8 * index).
  typedef enum logic [2:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_t;

  // Input item kind carried on tuser.
  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  // Per-push control that travels alongside the pixel column.
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } tag_t;

  // New window column delivered by the line stores.
  typedef struct packed {
    logic                   vld;
    logic [SAMPLE_BITS-1:0] top;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] bot;
  } col_t;

  // One finished result.
  typedef struct packed {
    logic [OUT_W-1:0] filtered;
    logic             last;
  } result_t;

  // Coefficient rows, index 0 is the top row.
  typedef logic [2:0][COEF_ROW_W-1:0] coef_rows_t;

  // Width register value as the datapath uses it: zero acts as one, large values saturate.
  function automatic logic [WIDTH_REG_W-1:0] clamp_width(input logic [WIDTH_REG_W-1:0] w);
    logic [WIDTH_REG_W-1:0] res;
    if (w == '0) begin
      res = WIDTH_REG_W'(1);
    end else if (w > WIDTH_REG_W'(MAX_WIDTH)) begin
      res = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      res = w;
    end
    return res;
  endfunction

  // Height register value as the datapath uses it: zero acts as one.
  function automatic logic [HEIGHT_REG_W-1:0] clamp_height(input logic [HEIGHT_REG_W-1:0] h);
    logic [HEIGHT_REG_W-1:0] res;
    if (h == '0) begin
      res = HEIGHT_REG_W'(1);
    end else begin
      res = h;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cnv2d_line_store.sv =====
// Two line memories (upper and middle image row) with read-modify-write per pushed column.
// Depends on cnv2d_pkg for widths and the column struct.
`default_nettype none

module cnv2d_line_store
  import cnv2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  input  wire logic [SAMPLE_BITS-1:0] pix_in,
  output col_t                        col_o
);

  logic [SAMPLE_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];

  logic [SAMPLE_BITS-1:0] upper_rd_r;
  logic [SAMPLE_BITS-1:0] middle_rd_r;
  logic                   s1_vld_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic [SAMPLE_BITS-1:0] s1_pix_r;
  logic                   fwd_r;
  logic                   fwd_nxt;
  logic [SAMPLE_BITS-1:0] fw_top_r;
  logic [SAMPLE_BITS-1:0] fw_mid_r;
  logic [SAMPLE_BITS-1:0] top_eff;
  logic [SAMPLE_BITS-1:0] mid_eff;

  // Synchronous read of both rows at the column being pushed.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd_r  <= upper_mem[rd_addr];
      middle_rd_r <= middle_mem[rd_addr];
    end
  end

  // Write back the next cycle: the middle row moves up, the new pixel becomes the middle row.
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      upper_mem[s1_addr_r]  <= mid_eff;
      middle_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  // With a one-pixel row the next read hits the entry being written; take the new values.
  assign fwd_nxt = s1_vld_r && rd_en && (rd_addr == s1_addr_r);

  always_comb begin
    top_eff = fwd_r ? fw_top_r : upper_rd_r;
    mid_eff = fwd_r ? fw_mid_r : middle_rd_r;
  end

  // Stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      fwd_r    <= fwd_nxt;
    end
  end

  // Stage payload and forwarded values.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr_r <= rd_addr;
      s1_pix_r  <= pix_in;
    end
    if (s1_vld_r) begin
      fw_top_r <= mid_eff;
      fw_mid_r <= s1_pix_r;
    end
  end

  // Column handed to the window.
  always_comb begin
    col_o.vld = s1_vld_r;
    col_o.top = top_eff;
    col_o.mid = mid_eff;
    col_o.bot = s1_pix_r;
  end

endmodule

`default_nettype wire

// ===== rtl/cnv2d_window_mac.sv =====
// 3x3 pixel window with edge masking, nine products and a two-level adder tree.
// Depends on cnv2d_pkg for the column, tag, coefficient and result types.
`default_nettype none

module cnv2d_window_mac
  import cnv2d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       clear_i,
  input  wire col_t       col_i,
  input  wire tag_t       tag_i,
  input  wire coef_rows_t coef_i,
  output logic            res_vld_o,
  output result_t         res_o
);

  logic [SAMPLE_BITS-1:0] win_r [3][3];
  tag_t                   s2_tag_r;

  logic [SAMPLE_BITS-1:0] pv      [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic                   s3_vld_r;
  logic                   s3_last_r;

  logic signed [ROW_W-1:0] row_nxt [3];
  logic signed [ROW_W-1:0] row_r   [3];
  logic                   s4_vld_r;
  logic                   s4_last_r;

  logic [OUT_W-1:0]       total_nxt;
  logic                   res_vld_r;
  result_t                res_r;
  logic [2:0]             row_ok;
  logic [2:0]             col_ok;

  // Window shift: the new column enters on the right.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (col_i.vld) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= col_i.top;
      win_r[1][2] <= col_i.mid;
      win_r[2][2] <= col_i.bot;
    end
  end

  // Tag follows the column into the window stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r <= '0;
    end else begin
      s2_tag_r <= col_i.vld ? tag_i : '0;
    end
  end

  // Neighbors outside the image count as zero.
  always_comb begin
    row_ok = {s2_tag_r.bot_ok, 1'b1, s2_tag_r.top_ok};
    col_ok = {s2_tag_r.right_ok, 1'b1, s2_tag_r.left_ok};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pv[r][c] = (row_ok[r] && col_ok[c]) ? win_r[r][c] : '0;
        prod_nxt[r][c] = PROD_W'($signed({1'b0, pv[r][c]}))
                       * PROD_W'($signed(coef_i[r][c*COEF_W +: COEF_W]));
      end
    end
  end

  // Row sums of the registered products, and the total of the registered row sums.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_nxt[r] = ROW_W'(prod_r[r][0]) + ROW_W'(prod_r[r][1]) + ROW_W'(prod_r[r][2]);
    end
    total_nxt = OUT_W'(row_r[0]) + OUT_W'(row_r[1]) + OUT_W'(row_r[2]);
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s3_vld_r  <= s2_tag_r.emit;
      s4_vld_r  <= s3_vld_r;
      res_vld_r <= s4_vld_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= prod_nxt[r][c];
      end
      row_r[r] <= row_nxt[r];
    end
    s3_last_r      <= s2_tag_r.last;
    s4_last_r      <= s3_last_r;
    res_r.filtered <= total_nxt;
    res_r.last     <= s4_last_r;
  end

  assign res_vld_o = res_vld_r;
  assign res_o     = res_r;

endmodule

`default_nettype wire

// ===== rtl/convolve_2d_zero_pad_top.sv =====
// Top level of the streaming 3x3 zero-padded convolution: registers, counters, result queue.
// Depends on cnv2d_pkg, cnv2d_line_store and cnv2d_window_mac.
//
// Usage:
//   Pixels of one image enter in raster order on the in_ stream (tuser = 0, tdata = pixel).
//   The result for pixel k leaves on the out_ stream once pixel k+W+1 has arrived; after
//   the last pixel, send one drain item (tuser = 1) per pending result, W+1 in all if H > 1.
//   out_tlast marks the last result of the image. Extra pixels and drains give nothing.
//   Throughput: one item per clock while in_tready is high. The first drain on an image of
//   a single row pushes two blank columns through the line memories, and in_tready drops
//   while the second is pushed. A result reaches out_tvalid through the line memory read,
//   window, product, row sum, total and queue stages, registered in that order.
//   An 8-entry result queue absorbs receiver stalls; in_tready drops while 8 results are
//   outstanding, so nothing is lost when the receiver stalls.
//   Configuration is a 64-bit APB port: coefficient rows at 0x00/0x08/0x10, width at 0x18,
//   height at 0x20. Writing width or height restarts the image. Write only when idle.
//   Reset (synchronous) restores the default Laplacian kernel, 640x480 geometry, and
//   empties the pipeline; line memories need no clearing pass.
`default_nettype none

module convolve_2d_zero_pad_top
  import cnv2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration port.
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel
  input  wire logic                   in_tuser,   // [0] mode
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [35:0] filtered, [39:36] zero
  output logic                        out_tlast   // last
);

  // Configuration registers and derived geometry.
  coef_rows_t                coef_r;
  coef_rows_t                coef_nxt;
  logic [WIDTH_REG_W-1:0]    width_r;
  logic [WIDTH_REG_W-1:0]    width_nxt;
  logic [HEIGHT_REG_W-1:0]   height_r;
  logic [HEIGHT_REG_W-1:0]   height_nxt;
  logic [WIDTH_REG_W-1:0]    w_eff_r;
  logic [WIDTH_REG_W-1:0]    w_eff_nxt;
  logic [HEIGHT_REG_W-1:0]   h_eff_r;
  logic [HEIGHT_REG_W-1:0]   h_eff_nxt;
  logic [CNT_W-1:0]          n_r;
  logic [CNT_W-1:0]          n_nxt;
  logic                      cfg_wr;
  logic                      geom_wr;
  cfg_reg_t                  cfg_sel;

  // Image position counters.
  logic [CNT_W-1:0]          in_cnt_r;
  logic [CNT_W-1:0]          in_cnt_nxt;
  logic [CNT_W-1:0]          out_cnt_r;
  logic [CNT_W-1:0]          out_cnt_nxt;
  logic [ADDR_W-1:0]         col_r;
  logic [ADDR_W-1:0]         col_nxt;
  logic [ADDR_W-1:0]         out_x_r;
  logic [ADDR_W-1:0]         out_x_nxt;
  logic [HEIGHT_REG_W-1:0]   out_y_r;
  logic [HEIGHT_REG_W-1:0]   out_y_nxt;
  logic [ADDR_W-1:0]         w_last;
  logic                      extra_r;
  logic                      extra_nxt;

  // Push issue.
  logic                      in_xfer;
  logic                      is_drain;
  logic                      in_lt_n;
  logic                      out_lt_n;
  logic                      past_warmup;
  logic                      need2;
  logic                      push_go;
  logic                      push_emit;
  logic [SAMPLE_BITS-1:0]    push_pix;
  tag_t                      push_tag;
  tag_t                      s1_tag_r;

  // Datapath links.
  col_t                      col;
  logic                      res_vld;
  result_t                   res;

  // Result queue and flow control.
  result_t                   fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_ptr_r;
  logic [FIFO_PTR_W-1:0]     rd_ptr_r;
  logic [CREDIT_W-1:0]       fifo_cnt_r;
  logic [CREDIT_W-1:0]       credit_r;
  logic                      out_xfer;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:3]);

  // Register writes; a geometry write also restarts the image.
  always_comb begin
    coef_nxt   = coef_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    geom_wr    = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_COEF_TOP: coef_nxt[0] = cfg_pwdata[COEF_ROW_W-1:0];
        REG_COEF_MID: coef_nxt[1] = cfg_pwdata[COEF_ROW_W-1:0];
        REG_COEF_BOT: coef_nxt[2] = cfg_pwdata[COEF_ROW_W-1:0];
        REG_WIDTH: begin
          width_nxt = cfg_pwdata[WIDTH_REG_W-1:0];
          geom_wr   = 1'b1;
        end
        REG_HEIGHT: begin
          height_nxt = cfg_pwdata[HEIGHT_REG_W-1:0];
          geom_wr    = 1'b1;
        end
        default: ;
      endcase
    end
    w_eff_nxt = clamp_width(width_nxt);
    h_eff_nxt = clamp_height(height_nxt);
    n_nxt     = CNT_W'(w_eff_nxt) * CNT_W'(h_eff_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= {COEF_BOT_RST, COEF_MID_RST, COEF_TOP_RST};
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      w_eff_r  <= WIDTH_RST;
      h_eff_r  <= HEIGHT_RST;
      n_r      <= NPIX_RST;
    end else begin
      coef_r   <= coef_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      w_eff_r  <= w_eff_nxt;
      h_eff_r  <= h_eff_nxt;
      n_r      <= n_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      REG_COEF_TOP: cfg_prdata = CFG_DATA_W'(coef_r[0]);
      REG_COEF_MID: cfg_prdata = CFG_DATA_W'(coef_r[1]);
      REG_COEF_BOT: cfg_prdata = CFG_DATA_W'(coef_r[2]);
      REG_WIDTH:    cfg_prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT:   cfg_prdata = CFG_DATA_W'(height_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Push issue: one column per pixel, blank columns for drains
  // ---------------------------------------------------------------------------
  assign in_tready = !extra_r && (credit_r < CREDIT_W'(FIFO_DEPTH));
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    is_drain    = (in_tuser == MODE_DRAIN);
    in_lt_n     = in_cnt_r < n_r;
    out_lt_n    = out_cnt_r < n_r;
    past_warmup = in_cnt_r > CNT_W'(w_eff_r);
    // A drain needs two blank columns when fewer than W+1 columns follow the next result.
    need2       = ((CNT_W+1)'(in_cnt_r) + (CNT_W+1)'(1))
                < ((CNT_W+1)'(out_cnt_r) + (CNT_W+1)'(w_eff_r) + (CNT_W+1)'(2));
    push_go     = 1'b0;
    push_emit   = 1'b0;
    push_pix    = '0;
    extra_nxt   = 1'b0;
    if (extra_r) begin
      // Second blank column of a short-image drain.
      push_go   = 1'b1;
      push_emit = 1'b1;
    end else if (in_xfer) begin
      if (!is_drain) begin
        push_go   = in_lt_n;
        push_emit = in_lt_n && past_warmup && out_lt_n;
        push_pix  = in_tdata[SAMPLE_BITS-1:0];
      end else if (!in_lt_n && out_lt_n) begin
        push_go = 1'b1;
        if (need2) begin
          extra_nxt = 1'b1;
        end else begin
          push_emit = 1'b1;
        end
      end
    end
  end

  // Edge flags and end-of-image flag for the result about to be formed.
  assign w_last = ADDR_W'(w_eff_r - WIDTH_REG_W'(1));

  always_comb begin
    push_tag.emit     = push_emit;
    push_tag.last     = (CNT_W'(out_cnt_r + CNT_W'(1)) == n_r);
    push_tag.top_ok   = (out_y_r != '0);
    push_tag.bot_ok   = (out_y_r != HEIGHT_REG_W'(h_eff_r - HEIGHT_REG_W'(1)));
    push_tag.left_ok  = (out_x_r != '0);
    push_tag.right_ok = (out_x_r != w_last);
  end

  // Position counters.
  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    col_nxt     = col_r;
    out_x_nxt   = out_x_r;
    out_y_nxt   = out_y_r;
    if (geom_wr) begin
      in_cnt_nxt  = '0;
      out_cnt_nxt = '0;
      col_nxt     = '0;
      out_x_nxt   = '0;
      out_y_nxt   = '0;
    end else begin
      if (push_go) begin
        in_cnt_nxt = CNT_W'(in_cnt_r + CNT_W'(1));
        col_nxt    = (col_r == w_last) ? '0 : ADDR_W'(col_r + ADDR_W'(1));
      end
      if (push_emit) begin
        out_cnt_nxt = CNT_W'(out_cnt_r + CNT_W'(1));
        if (out_x_r == w_last) begin
          out_x_nxt = '0;
          out_y_nxt = HEIGHT_REG_W'(out_y_r + HEIGHT_REG_W'(1));
        end else begin
          out_x_nxt = ADDR_W'(out_x_r + ADDR_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      col_r     <= '0;
      out_x_r   <= '0;
      out_y_r   <= '0;
      extra_r   <= 1'b0;
      s1_tag_r  <= '0;
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      col_r     <= col_nxt;
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
      extra_r   <= extra_nxt && !geom_wr;
      s1_tag_r  <= push_go ? push_tag : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  cnv2d_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (push_go),
    .rd_addr (col_r),
    .pix_in  (push_pix),
    .col_o   (col)
  );

  cnv2d_window_mac u_window_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_i   (geom_wr),
    .col_i     (col),
    .tag_i     (s1_tag_r),
    .coef_i    (coef_r),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = OUT_TDATA_W'(fifo_mem[rd_ptr_r].filtered);
  assign out_tlast  = fifo_mem[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (res_vld) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  // Pointers, fill level and outstanding-result credits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                  : FIFO_PTR_W'(wr_ptr_r + FIFO_PTR_W'(1));
      end
      if (out_xfer) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                  : FIFO_PTR_W'(rd_ptr_r + FIFO_PTR_W'(1));
      end
      fifo_cnt_r <= CREDIT_W'(fifo_cnt_r + CREDIT_W'(res_vld) - CREDIT_W'(out_xfer));
      credit_r   <= CREDIT_W'(credit_r + CREDIT_W'(push_emit) - CREDIT_W'(out_xfer));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cnv2d_checker.sv =====
// Port-level checker for the convolution top level, attached by a bind statement.
// Depends on cnv2d_pkg and binds into convolve_2d_zero_pad_top.
`default_nettype none

module cnv2d_checker
  import cnv2d_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result pending right after reset");

  // A result into an empty queue comes from an earlier input transfer through the pipeline;
  // a short-image drain that pushes two blank columns emits with its second column.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 6) || $past(in_tvalid && in_tready, 7))
    else $error("result appeared without a matching input transfer");

  // The input stalls only for the second column of a drain or when results back up.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid || $past(in_tvalid && in_tready))
    else $error("input stalled without cause");

endmodule

bind convolve_2d_zero_pad_top cnv2d_checker u_cnv2d_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for convolve_2d_zero_pad_top: streams images of many sizes and
// kernels, predicts every filtered pixel and compares it with the result stream.
// Depends on cnv2d_pkg and the RTL of the block only.

module tb_top;
  import cnv2d_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [15:0] pixel;
  } stim_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_t;

  localparam int SETTLE_CYCLES    = 12;
  localparam int HOLD_PERIOD      = 1500;
  localparam int HOLD_LEN         = 150;
  localparam int HOLD_MIN_PENDING = 16;
  localparam int RANDOM_ITEMS     = 370;
  localparam int MAX_REPORTS      = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;   // [15:0] pixel
  logic                   in_tuser  = 1'b0; // [0] mode

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [35:0] filtered, [39:36] zero
  logic                   out_tlast;

  convolve_2d_zero_pad_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #5 clk = ~clk;

  // Shadow copy of the registers and of the image position.
  logic [COEF_ROW_W-1:0]   coef_row [3];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      pix_count;
  int                      filt_count;
  logic [15:0]             image_pixels [$];

  stim_t   pending_items [$];
  result_t expected_results [$];

  int error_count   = 0;
  int checked_count = 0;
  int items_queued  = 0;
  int images_done   = 0;

  // Driver and receiver state.
  stim_t       sent_item;
  int          burst_left = 0;
  int          gap_left   = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  int          rx_pattern_left = 0;
  int          rx_cycle   = 0;
  int          hold_left  = 0;
  int          next_hold  = 0;
  result_t     mon_expect;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic int active_width();
    if (width_reg == '0) begin
      return 1;
    end
    if (int'(width_reg) > MAX_WIDTH) begin
      return MAX_WIDTH;
    end
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // Zero-padded 3x3 correlation at the next output position, taken from the stored image.
  function automatic result_t next_window_sum();
    int      w;
    int      h;
    int      y;
    int      x;
    int      iy;
    int      ix;
    longint  acc;
    longint  coef;
    result_t r;
    w   = active_width();
    h   = active_height();
    y   = filt_count / w;
    x   = filt_count % w;
    acc = 0;
    for (int fy = 0; fy < 3; fy++) begin
      for (int fx = 0; fx < 3; fx++) begin
        iy = y + fy - 1;
        ix = x + fx - 1;
        if (iy >= 0 && iy < h && ix >= 0 && ix < w) begin
          coef = longint'($signed(coef_row[fy][16*fx +: 16]));
          acc += longint'(image_pixels[iy*w + ix]) * coef;
        end
      end
    end
    filt_count++;
    r.filtered = acc[OUT_W-1:0];
    r.last     = (filt_count == w * h);
    return r;
  endfunction

  // Advances the image position for one accepted item and queues the result it causes.
  function automatic void convolve_transfer(input stim_t item);
    int w;
    int n;
    w = active_width();
    n = w * active_height();
    if (item.mode == MODE_PIXEL) begin
      if (pix_count >= n) begin
        return;
      end
      image_pixels.push_back(item.pixel);
      pix_count++;
      if (pix_count > w + 1 && filt_count < n) begin
        expected_results.push_back(next_window_sum());
      end
    end else begin
      if (pix_count < n || filt_count >= n) begin
        return;
      end
      // Blank columns beyond the image are pushed as needed; they only feed padding.
      if (pix_count < filt_count + w + 2) begin
        pix_count = filt_count + w + 2;
      end
      expected_results.push_back(next_window_sum());
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        convolve_transfer(sent_item);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          sent_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= sent_item.pixel;
          in_tuser  <= sent_item.mode;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a changing stall pattern, with a long hold-off while many items wait to be sent.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left == 0 && rx_cycle >= next_hold
          && pending_items.size() >= HOLD_MIN_PENDING) begin
        hold_left = HOLD_LEN;
        next_hold = rx_cycle + HOLD_PERIOD;
      end
      if (rx_pattern_left == 0) begin
        rx_pattern      = rx_pattern_t'($urandom_range(0, 3));
        rx_pattern_left = $urandom_range(16, 96);
      end else begin
        rx_pattern_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h last %b with none expected",
                                  out_tdata, out_tlast));
      end else begin
        mon_expect = expected_results.pop_front();
        checked_count++;
        if (out_tdata[OUT_W-1:0] !== mon_expect.filtered) begin
          report_mismatch($sformatf("result %0d: filtered %h, expected %h", checked_count,
                                    out_tdata[OUT_W-1:0], mon_expect.filtered));
        end
        if (out_tlast !== mon_expect.last) begin
          report_mismatch($sformatf("result %0d: last %b, expected %b", checked_count,
                                    out_tlast, mon_expect.last));
        end
        if (out_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
          report_mismatch($sformatf("result %0d: padding bits %h not zero", checked_count,
                                    out_tdata[OUT_TDATA_W-1:OUT_W]));
        end
        if (mon_expect.last) begin
          images_done++;
        end
      end
    end
  end

  // Register write: setup cycle, then access cycle; the shadow copy follows.
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(int'(idx) * 8);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_COEF_TOP: coef_row[0] = value[COEF_ROW_W-1:0];
      REG_COEF_MID: coef_row[1] = value[COEF_ROW_W-1:0];
      REG_COEF_BOT: coef_row[2] = value[COEF_ROW_W-1:0];
      default: begin
        if (idx == REG_WIDTH) begin
          width_reg = value[WIDTH_REG_W-1:0];
        end else begin
          height_reg = value[HEIGHT_REG_W-1:0];
        end
        // Geometry writes restart the image.
        pix_count  = 0;
        filt_count = 0;
        image_pixels.delete();
      end
    endcase
  endtask

  task automatic set_kernel(input logic [COEF_ROW_W-1:0] top, input logic [COEF_ROW_W-1:0] mid,
                            input logic [COEF_ROW_W-1:0] bot);
    cfg_write(REG_COEF_TOP, {16'($urandom), top});
    cfg_write(REG_COEF_MID, {16'($urandom), mid});
    cfg_write(REG_COEF_BOT, {16'($urandom), bot});
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  task automatic queue_item(input mode_t mode, input logic [15:0] pixel);
    stim_t item;
    item.mode  = mode;
    item.pixel = pixel;
    pending_items.push_back(item);
    items_queued++;
  endtask

  function automatic logic [15:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_coef();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'($urandom_range(0, 2047)) - 16'd1024;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [COEF_ROW_W-1:0] random_coef_row();
    return {random_coef(), random_coef(), random_coef()};
  endfunction

  // Queues npix pixels of the current image; a complete image also gets its drains.
  // Noisy images carry early drains and, now and then, surplus items at the end.
  task automatic queue_image(input int npix, input bit noisy);
    int w;
    int n;
    w = active_width();
    n = w * active_height();
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        queue_item(MODE_DRAIN, 16'($urandom));
      end
      queue_item(MODE_PIXEL, random_pixel());
    end
    if (npix == n) begin
      for (int i = 0; i < w + 1; i++) begin
        queue_item(MODE_DRAIN, 16'($urandom));
      end
      if (noisy && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) queue_item(MODE_DRAIN, 16'($urandom));
        repeat ($urandom_range(1, 3)) queue_item(MODE_PIXEL, random_pixel());
      end
    end
  endtask

  // Waits until every item is sent and every result has come, plus the pipeline depth.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int start_items;
    int w_sel;
    int h_sel;
    int n;
    logic [CFG_DATA_W-1:0] w_value;

    coef_row[0] = COEF_TOP_RST;
    coef_row[1] = COEF_MID_RST;
    coef_row[2] = COEF_BOT_RST;
    width_reg   = WIDTH_RST;
    height_reg  = HEIGHT_RST;
    pix_count   = 0;
    filt_count  = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Largest positive sums on a 3x2 image, with an early drain, surplus drain and pixel.
    set_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    set_geometry(64'd3, 64'd2);
    queue_item(MODE_DRAIN, 16'hFFFF);
    repeat (6) queue_item(MODE_PIXEL, 16'hFFFF);
    repeat (5) queue_item(MODE_DRAIN, 16'h0000);
    queue_item(MODE_PIXEL, 16'hFFFF);
    wait_idle();

    // Most negative kernel; zero width and height act as a single pixel.
    set_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    set_geometry(64'd0, 64'd0);
    queue_item(MODE_PIXEL, 16'hFFFF);
    queue_item(MODE_DRAIN, 16'hFFFF);
    queue_item(MODE_DRAIN, 16'h0000);
    wait_idle();

    // Single-row image short enough that the first drain pushes blank columns itself.
    set_kernel(48'h0000_0000_0000, 48'h7FFF_8000_0001, 48'h0000_0000_0000);
    set_geometry(64'd2, 64'd1);
    queue_item(MODE_PIXEL, 16'hFFFF);
    queue_item(MODE_PIXEL, 16'h0001);
    repeat (3) queue_item(MODE_DRAIN, 16'h5A5A);
    wait_idle();

    // Tallest image, left unfinished; the next geometry write restarts it.
    set_kernel(random_coef_row(), random_coef_row(), random_coef_row());
    set_geometry(64'd3, 64'hFFFF);
    queue_image(30, 1'b1);
    wait_idle();

    // Width beyond the line stores saturates to their full size; a partial row gives nothing.
    set_geometry(64'h7FF, 64'd1);
    queue_image(24, 1'b1);
    wait_idle();

    // Random images: mostly complete and well formed, some cut short.
    start_items = items_queued;
    while (items_queued - start_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: ;
        1: set_kernel(random_coef_row(), random_coef_row(), random_coef_row());
        2: set_kernel(COEF_TOP_RST, COEF_MID_RST, COEF_BOT_RST);
        default: cfg_write(REG_COEF_MID, {16'($urandom), random_coef_row()});
      endcase
      w_sel = $urandom_range(0, 19);
      if (w_sel == 0) begin
        w_value = '0;
      end else if (w_sel <= 2) begin
        w_value = CFG_DATA_W'($urandom_range(13, 40));
      end else begin
        w_value = CFG_DATA_W'($urandom_range(1, 12));
      end
      // Bits above the register width are dropped by the block.
      if ($urandom_range(0, 3) == 0) begin
        w_value = {$urandom, 21'($urandom), w_value[10:0]};
      end
      h_sel = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 1) == 0) begin
        set_geometry(w_value, CFG_DATA_W'(h_sel));
      end else begin
        cfg_write(REG_HEIGHT, CFG_DATA_W'(h_sel));
        cfg_write(REG_WIDTH, w_value);
      end
      n = active_width() * active_height();
      if ($urandom_range(0, 7) == 0) begin
        queue_image($urandom_range(0, n - 1), 1'b1);
      end else begin
        queue_image(n, 1'b1);
      end
      wait_idle();
    end

    $display("Run covered %0d complete images, %0d checked results and %0d input items,",
             images_done, checked_count, items_queued);
    $display("including one-pixel, one-row, full-width and unfinished images.");
    if (error_count == 0) begin
      $display("** convolve_2d_zero_pad_top: PASSED **");
    end else begin
      $display("** convolve_2d_zero_pad_top: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("** convolve_2d_zero_pad_top: FAILED **");
    $finish;
  end

endmodule
